/* hdl/lemmq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lemmq_pkg
// Shared types and codes of the line envelope min/max query block.
// ----------------------------------------------------------------------------
package lemmq_pkg;

   localparam int VAL_W   = 32;
   localparam int BEST_W  = 64;
   localparam int CSR_IDX_W = 2;

   // command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_DOMAIN = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_MAX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_LEFT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RIGHT  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_A_READ,
      S_A_LOAD,
      S_A_EV0,
      S_A_EV1,
      S_A_EV2,
      S_A_EV3,
      S_A_LINK,
      S_A_WB,
      S_A_NEW,
      S_Q_READ,
      S_Q_LOAD,
      S_Q_EV0,
      S_Q_EV1,
      S_Q_EV2,
      S_RESP
   } ctrl_state_type;

   // which point of the interval an add compares at
   typedef enum logic [1:0] {
      PH_MID,
      PH_LO,
      PH_HI
   } phase_type;

endpackage

/* hdl/line_envelope_min_max_query.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_envelope_min_max_query
// Li Chao tree of lines over [x_left, x_right), min or max envelope.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. req_cmd selects an
//   add of line (req_slope, req_intercept) or a query at req_x_value.
//   Exactly one result per item appears on rsp_status / rsp_best_value for
//   one cycle with rsp_valid high; the receiver cannot stall it.
//   Registers are written through csr_valid/csr_ready (always ready) with
//   csr_index 0 mode_max, 1 x_left, 2 x_right; others are ignored.
// Structure:
//   Nodes live in one synchronous RAM; one shared two-stage evaluator does
//   all line values. A query reads, loads and evaluates one node per tree
//   level visited. An add does per level a read, a load, up to three
//   paired evaluations, a link when needed and a write-back, then
//   allocates a node at an empty child. Early exits go straight to a result.
// Reset:
//   Synchronous reset empties the tree (node count to zero) and restores
//   mode_max = 0, x_left = 0, x_right = 65536. Node RAM is not cleared.
// ----------------------------------------------------------------------------
module line_envelope_min_max_query
   import lemmq_pkg::*;
#(
   parameter int MAX_NODES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic signed [VAL_W-1:0]  req_slope,
   input  logic signed [VAL_W-1:0]  req_intercept,
   input  logic signed [VAL_W-1:0]  req_x_value,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [BEST_W-1:0] rsp_best_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [VAL_W-1:0]         csr_wdata
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int RW = 2 * VAL_W + 2 * AW;

   ctrl_state_type state_ff, state_in;
   phase_type      phase_ff;

   logic                    mode_ff;
   logic signed [VAL_W-1:0] xl_ff, xr_ff;
   logic [CW-1:0]           count_ff;

   logic signed [VAL_W-1:0] p_ff, q_ff, pt_ff, lo_ff, hi_ff, mid_ff;
   logic signed [VAL_W-1:0] sp_ff, sq_ff;
   logic [AW-1:0]           lc_ff, rc_ff, u_ff, nxt_ff;
   logic signed [BEST_W-1:0] va_ff, best_ff;
   logic [1:0]              status_ff;
   logic                    dir_ff, alloc_ff, cont_ff, first_ff;

   // ram and evaluator hookup
   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [RW-1:0]           ram_wdata, ram_rdata;
   logic                    ev_node;
   logic signed [VAL_W-1:0] ev_slope, ev_icpt;
   logic signed [BEST_W-1:0] ev_val;

   lemmq_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (u_ff),
      .rdata (ram_rdata)
   );

   lemmq_eval u_eval (
      .clock     (clock),
      .slope     (ev_slope),
      .intercept (ev_icpt),
      .x         (pt_ff),
      .value     (ev_val)
   );

   // interval arithmetic
   logic signed [VAL_W:0] diff, mid_w;
   logic                  unit_w;
   assign diff   = {hi_ff[VAL_W-1], hi_ff} - {lo_ff[VAL_W-1], lo_ff};
   assign mid_w  = {lo_ff[VAL_W-1], lo_ff} + (diff >>> 1);
   assign unit_w = (diff == (VAL_W+1)'(1));

   // comparison of the two evaluated lines
   logic win;
   assign win = mode_ff ? (va_ff > ev_val) : (va_ff < ev_val);

   // query path step
   logic                    q_better, q_stop;
   logic [AW-1:0]           q_child;
   logic signed [BEST_W-1:0] q_newb;
   assign q_better = mode_ff ? (ev_val > best_ff) : (ev_val < best_ff);
   assign q_newb   = (first_ff || q_better) ? ev_val : best_ff;
   assign q_child  = (pt_ff < mid_ff) ? lc_ff : rc_ff;
   assign q_stop   = (q_child == '0) || (CW'(q_child) >= count_ff);

   // add descent link
   logic [AW-1:0] link_w;
   logic          pool_full;
   assign link_w    = dir_ff ? rc_ff : lc_ff;
   assign pool_full = (count_ff == CW'(MAX_NODES));

   // item checks at accept
   logic accept, q_empty, q_out, a_bad;
   assign accept  = start && !busy;
   assign q_empty = (count_ff == '0);
   assign q_out   = (req_x_value < xl_ff) || (req_x_value >= xr_ff);
   assign a_bad   = (xr_ff <= xl_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_QUERY) begin
                  state_in = (q_empty || q_out) ? S_RESP : S_Q_READ;
               end else if (a_bad) begin
                  state_in = S_RESP;
               end else begin
                  state_in = q_empty ? S_A_NEW : S_A_READ;
               end
            end
         end
         S_A_READ: state_in = S_A_LOAD;
         S_A_LOAD: state_in = S_A_EV0;
         S_A_EV0:  state_in = S_A_EV1;
         S_A_EV1:  state_in = S_A_EV2;
         S_A_EV2:  state_in = S_A_EV3;
         S_A_EV3: begin
            case (phase_ff)
               PH_MID:  state_in = unit_w ? S_A_WB : S_A_EV0;
               PH_LO:   state_in = win ? S_A_LINK : S_A_EV0;
               PH_HI:   state_in = win ? S_A_LINK : S_A_WB;
               default: state_in = S_A_WB;
            endcase
         end
         S_A_LINK: state_in = S_A_WB;
         S_A_WB: begin
            if (alloc_ff) begin
               state_in = S_A_NEW;
            end else if (cont_ff) begin
               state_in = S_A_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_A_NEW:  state_in = S_RESP;
         S_Q_READ: state_in = S_Q_LOAD;
         S_Q_LOAD: state_in = S_Q_EV0;
         S_Q_EV0:  state_in = S_Q_EV1;
         S_Q_EV1:  state_in = S_Q_EV2;
         S_Q_EV2:  state_in = q_stop ? S_RESP : S_Q_READ;
         S_RESP:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs, ram writes and evaluator operand select
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = u_ff;
      ram_wdata = {sp_ff, sq_ff, lc_ff, rc_ff};
      ev_node   = 1'b0;
      case (state_ff)
         S_A_WB: ram_we = 1'b1;
         S_A_NEW: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[AW-1:0];
            ram_wdata = {p_ff, q_ff, {AW{1'b0}}, {AW{1'b0}}};
         end
         S_A_EV1: ev_node = 1'b1;
         S_Q_EV0: ev_node = 1'b1;
         default: ev_node = 1'b0;
      endcase
   end

   assign ev_slope       = ev_node ? sp_ff : p_ff;
   assign ev_icpt        = ev_node ? sq_ff : q_ff;
   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_best_value = best_ff;
   assign csr_ready      = 1'b1;

   // control registers and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= 1'b0;
         xl_ff    <= '0;
         xr_ff    <= VAL_W'(65536);
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE_MAX: mode_ff <= csr_wdata[0];
               CSR_X_LEFT:   xl_ff   <= csr_wdata;
               CSR_X_RIGHT:  xr_ff   <= csr_wdata;
               default:      mode_ff <= mode_ff;
            endcase
         end
         if (state_ff == S_A_NEW) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               p_ff     <= req_slope;
               q_ff     <= req_intercept;
               pt_ff    <= req_x_value;
               lo_ff    <= xl_ff;
               hi_ff    <= xr_ff;
               u_ff     <= '0;
               first_ff <= 1'b1;
               best_ff  <= '0;
               if (req_cmd == CMD_QUERY) begin
                  if (q_empty) begin
                     status_ff <= STATUS_EMPTY;
                  end else if (q_out) begin
                     status_ff <= STATUS_DOMAIN;
                  end else begin
                     status_ff <= STATUS_OK;
                  end
               end else begin
                  status_ff <= a_bad ? STATUS_DOMAIN : STATUS_OK;
               end
            end
         end
         S_A_LOAD, S_Q_LOAD: begin
            {sp_ff, sq_ff, lc_ff, rc_ff} <= ram_rdata;
            mid_ff <= mid_w[VAL_W-1:0];
            if (state_ff == S_A_LOAD) begin
               pt_ff    <= mid_w[VAL_W-1:0];
               phase_ff <= PH_MID;
            end
         end
         S_A_EV2: va_ff <= ev_val;
         S_A_EV3: begin
            alloc_ff <= 1'b0;
            cont_ff  <= 1'b0;
            case (phase_ff)
               PH_MID: begin
                  // new line better at the midpoint takes the node
                  if (win) begin
                     sp_ff <= p_ff;
                     sq_ff <= q_ff;
                     p_ff  <= sp_ff;
                     q_ff  <= sq_ff;
                  end
                  phase_ff <= PH_LO;
                  pt_ff    <= lo_ff;
               end
               PH_LO: begin
                  if (win) begin
                     dir_ff <= 1'b0;
                     hi_ff  <= mid_ff;
                  end else begin
                     phase_ff <= PH_HI;
                     pt_ff    <= hi_ff - VAL_W'(1);
                  end
               end
               PH_HI: begin
                  if (win) begin
                     dir_ff <= 1'b1;
                     lo_ff  <= mid_ff;
                  end
               end
               default: phase_ff <= PH_MID;
            endcase
         end
         S_A_LINK: begin
            if (link_w == '0) begin
               if (pool_full) begin
                  status_ff <= STATUS_FULL;
               end else begin
                  alloc_ff <= 1'b1;
                  if (dir_ff) begin
                     rc_ff <= count_ff[AW-1:0];
                  end else begin
                     lc_ff <= count_ff[AW-1:0];
                  end
               end
            end else begin
               cont_ff <= 1'b1;
               nxt_ff  <= link_w;
            end
         end
         S_A_WB: begin
            if (cont_ff) begin
               u_ff <= nxt_ff;
            end
         end
         S_Q_EV2: begin
            best_ff  <= q_newb;
            first_ff <= 1'b0;
            if (pt_ff < mid_ff) begin
               hi_ff <= mid_ff;
            end else begin
               lo_ff <= mid_ff;
            end
            u_ff <= q_child;
         end
         default: u_ff <= u_ff;
      endcase
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count above pool size");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_best_value == '0))
      else $error("failed item carries a nonzero value");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

endmodule

/* hdl/lemmq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lemmq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lemmq_ram #(
   parameter int WIDTH = 84,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* hdl/lemmq_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lemmq_eval
// Two-stage line evaluator: value = slope * x + intercept.
// ----------------------------------------------------------------------------
module lemmq_eval
   import lemmq_pkg::*;
(
   input  logic                     clock,
   input  logic signed [VAL_W-1:0]  slope,
   input  logic signed [VAL_W-1:0]  intercept,
   input  logic signed [VAL_W-1:0]  x,
   output logic signed [BEST_W-1:0] value
);

   logic signed [BEST_W-1:0] prod_ff;
   logic signed [VAL_W-1:0]  icpt_ff;
   logic signed [BEST_W-1:0] val_ff;

   // multiply stage, then add stage
   always_ff @(posedge clock) begin
      prod_ff <= slope * x;
      icpt_ff <= intercept;
      val_ff  <= prod_ff + BEST_W'(icpt_ff);
   end

   assign value = val_ff;

endmodule
